### src/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared constants, widths and controller/datapath interface types for the
// quadratic probing hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

    // Store geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int SIZE_W = 11;
    localparam int KEY_W  = 31;
    localparam int SLOT_W = 32;
    localparam int RC_W   = 2;
    localparam int DIV_W  = $clog2(KEY_W);

    // Register reset and empty mark
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
    localparam logic [SLOT_W-1:0] SLOT_EMPTY = {SLOT_W{1'b1}};

    // Request types
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Result codes
    localparam logic [RC_W-1:0] RC_NOT_FOUND = 2'd0;
    localparam logic [RC_W-1:0] RC_FOUND     = 2'd1;
    localparam logic [RC_W-1:0] RC_INSERTED  = 2'd2;
    localparam logic [RC_W-1:0] RC_FULL      = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;
        logic start;
        logic div_step;
        logic probe_init;
        logic probe_step;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic            clr_last;
        logic            div_last;
        logic            probe_done;
        logic [RC_W-1:0] probe_code;
    } t_dp_stat;

endpackage

### src/qpht_datapath.sv
// ----------------------------------------------------------------------------
// qpht_datapath
// Slot store, size register, bit-serial home-slot remainder and the
// incremental quadratic probe sequence with its match logic.
// ----------------------------------------------------------------------------
module qpht_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  qpht_pkg::t_dp_cmd         i_cmd,
    output qpht_pkg::t_dp_stat        o_stat,
    input  logic                      i_req_type,
    input  logic [qpht_pkg::KEY_W-1:0]  i_key,
    input  logic                      i_cfg_we,
    input  logic [qpht_pkg::SIZE_W-1:0] i_cfg_data
);
    import qpht_pkg::*;

    logic [SLOT_W-1:0] mem [TABLE_DEPTH];

    logic [SIZE_W-1:0] r_table_size;
    logic [IDX_W-1:0]  r_clr_addr;
    logic [CNT_W-1:0]  r_n;
    logic [KEY_W-1:0]  r_key;
    logic              r_req;
    logic [IDX_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div_cnt;
    logic [IDX_W-1:0]  r_slot;
    logic [IDX_W-1:0]  r_d;
    logic [CNT_W-1:0]  r_issue_cnt;
    logic [IDX_W-1:0]  r_rd_slot;
    logic              r_rd_vld;
    logic [SLOT_W-1:0] r_rd_data;

    logic [31:0]       cfg_ext;
    logic [CNT_W-1:0]  eff_n;
    logic [CNT_W:0]    div_t;
    logic [CNT_W:0]    n_ext;
    logic [IDX_W-1:0]  n_rem;
    logic [CNT_W:0]    slot_sum;
    logic [IDX_W-1:0]  n_slot;
    logic [CNT_W:0]    d_t0;
    logic [CNT_W:0]    d_t1;
    logic [IDX_W-1:0]  n_d;
    logic              issue;
    logic              hit_empty;
    logic              hit_key;
    logic              probe_hit;
    logic              exhausted;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [SLOT_W-1:0] mem_wdata;

    // Clamp the size register into one to depth
    always_comb begin
        cfg_ext = 32'(r_table_size);
        if (cfg_ext == 32'd0) begin
            eff_n = CNT_W'(1);
        end else if (cfg_ext > 32'(TABLE_DEPTH)) begin
            eff_n = CNT_W'(TABLE_DEPTH);
        end else begin
            eff_n = CNT_W'(cfg_ext);
        end
    end

    // One restoring remainder step, key bits MSB first
    always_comb begin
        n_ext = (CNT_W+1)'(r_n);
        div_t = (CNT_W+1)'({r_rem, r_key[r_div_cnt]});
        if (div_t >= n_ext) begin
            div_t = div_t - n_ext;
        end
        n_rem = IDX_W'(div_t);
    end

    // Advance slot by the step, and the step by two, both mod n
    always_comb begin
        slot_sum = (CNT_W+1)'(r_slot) + (CNT_W+1)'(r_d);
        if (slot_sum >= n_ext) begin
            slot_sum = slot_sum - n_ext;
        end
        n_slot = IDX_W'(slot_sum);
        d_t0 = (CNT_W+1)'(r_d) + (CNT_W+1)'(2);
        if (d_t0 >= n_ext) begin
            d_t0 = d_t0 - n_ext;
        end
        d_t1 = d_t0;
        if (d_t1 >= n_ext) begin
            d_t1 = d_t1 - n_ext;
        end
        n_d = IDX_W'(d_t1);
    end

    // Check the slot that came back from the store
    assign hit_empty = (r_rd_data == SLOT_EMPTY);
    assign hit_key   = (r_rd_data == {1'b0, r_key});
    assign probe_hit = r_rd_vld && (hit_empty || (r_req == REQ_SEARCH && hit_key));
    assign exhausted = !r_rd_vld && (r_issue_cnt == r_n);
    assign issue     = i_cmd.probe_step && (r_issue_cnt != r_n);

    always_comb begin
        o_stat.clr_last   = (r_clr_addr == IDX_W'(TABLE_DEPTH - 1));
        o_stat.div_last   = (r_div_cnt == '0);
        o_stat.probe_done = probe_hit || exhausted;
        if (r_req == REQ_INSERT) begin
            o_stat.probe_code = probe_hit ? RC_INSERTED : RC_FULL;
        end else begin
            o_stat.probe_code = (probe_hit && hit_key) ? RC_FOUND : RC_NOT_FOUND;
        end
    end

    // Select the store write: clearing pass or insert into an empty slot
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_rd_slot;
        mem_wdata = {1'b0, r_key};
        if (i_cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = SLOT_EMPTY;
        end else if (i_cmd.probe_step && probe_hit && r_req == REQ_INSERT) begin
            mem_we = 1'b1;
        end
    end

    // Slot store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_slot];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_RESET;
            r_clr_addr   <= '0;
            r_rd_vld     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_table_size <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + IDX_W'(1);
            end
            if (i_cmd.probe_init) begin
                r_rd_vld <= 1'b0;
            end else if (i_cmd.probe_step) begin
                r_rd_vld <= issue;
            end
        end
    end

    // Request, remainder and probe sequence registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key     <= i_key;
            r_req     <= i_req_type;
            r_n       <= eff_n;
            r_rem     <= '0;
            r_div_cnt <= DIV_W'(KEY_W - 1);
        end
        if (i_cmd.div_step) begin
            r_rem     <= n_rem;
            r_div_cnt <= r_div_cnt - DIV_W'(1);
        end
        if (i_cmd.probe_init) begin
            r_slot      <= r_rem;
            r_d         <= (r_n == CNT_W'(1)) ? IDX_W'(0) : IDX_W'(1);
            r_issue_cnt <= '0;
        end else if (issue) begin
            r_slot      <= n_slot;
            r_d         <= n_d;
            r_issue_cnt <= r_issue_cnt + CNT_W'(1);
            r_rd_slot   <= r_slot;
        end
    end

endmodule

### src/qpht_ctrl.sv
// ----------------------------------------------------------------------------
// qpht_ctrl
// Request sequencer: clearing pass, remainder, probing, and the output
// register of the result channel.
// ----------------------------------------------------------------------------
module qpht_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [qpht_pkg::RC_W-1:0]  o_result_code,
    output qpht_pkg::t_dp_cmd          o_cmd,
    input  qpht_pkg::t_dp_stat         i_stat
);
    import qpht_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_PINIT,
        S_PROBE,
        S_OUT
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic [RC_W-1:0] r_out_code;
    logic [RC_W-1:0] n_out_code;
    logic [RC_W-1:0] r_code;
    logic [RC_W-1:0] n_code;
    logic            out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_code      = r_code;
        n_out_code  = r_out_code;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_PINIT;
                end
            end
            S_PINIT: begin
                o_cmd.probe_init = 1'b1;
                n_state          = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe_step = 1'b1;
                if (i_stat.probe_done) begin
                    n_code  = i_stat.probe_code;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_code  = r_code;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_code     <= n_code;
        r_out_code <= n_out_code;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_result_code = r_out_code;

endmodule

### src/quadratic_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_top
// Open-addressing hash table of 31-bit keys with quadratic probing.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall) carries i_req_type (0 insert,
//   1 search) and i_key. A transaction completes when valid is high and
//   stall is low. Result channel (o_out_valid / i_out_stall) returns one
//   o_result_code per request: 0 not found, 1 found, 2 inserted, 3 full.
//   i_cfg_we writes i_cfg_data into the table size register (0 acts as 1,
//   values above the depth act as the depth); write it only while idle.
// Sequence: bit-serial key mod size, one remainder step per key bit, a
//   setup state, then one store read per probe with a registered read (at
//   most size probes), and the move into the output register. One request
//   is in work at a time; the next is taken once the result has entered the
//   output register.
// Reset: a clearing pass writes the empty mark into all 1024 slots, one per
//   cycle; requests stall during the pass, config writes are taken.
// Stall: a held result stays in the output register; one more finished
//   result waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [qpht_pkg::KEY_W-1:0]  i_key,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [qpht_pkg::RC_W-1:0]   o_result_code,
    input  logic                        i_cfg_we,
    input  logic [qpht_pkg::SIZE_W-1:0] i_cfg_data
);
    import qpht_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sequencer
    qpht_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_code (o_result_code),
        .o_cmd         (cmd),
        .i_stat        (stat)
    );

    // Store and probe arithmetic
    qpht_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_req_type (i_req_type),
        .i_key      (i_key),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

endmodule
